### rtl/core/fpalu_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
`default_nettype none

package fpalu_pkg;

    // Operation codes carried in the operation field.
    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT   = 4'd9
    } op_t;

    // Saturation bounds of the signed 32-bit result.
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // One input item.
    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic signed [31:0] result_value;
        logic               a_greater;
        logic               a_less;
        logic               a_equal;
        logic               divide_by_zero;
        logic               overflow;
    } out_item_t;

    // Data that travels beside the divider stages.
    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] simple;
        logic [31:0] ma;
        logic [31:0] mb;
        logic        neg;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        dbz;
    } side_t;

endpackage

`default_nettype wire

### rtl/core/fpalu_mul.sv
// Registered 32x32 unsigned magnitude multiplier.
`default_nettype none

module fpalu_mul (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] ma,
    input  wire logic [31:0] mb,
    output logic      [63:0] prod_reg
);

    // One product per cycle, held while the pipeline is stalled.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 64'(ma) * 64'(mb);
        end
    end

endmodule

`default_nettype wire

### rtl/core/fpalu_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module fpalu_div #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire logic [31:0]            ma,
    input  wire logic [31:0]            mb,
    output logic      [FRAC_BITS+32:0]  quot
);

    // The dividend is the magnitude scaled by two and by the fraction weight.
    localparam int DIV_W = FRAC_BITS + 33;

    logic [31:0]      rem_reg [DIV_W-1];
    logic [31:0]      dvs_reg [DIV_W-1];
    logic [DIV_W-1:0] dq_reg  [DIV_W];

    for (genvar i = 0; i < DIV_W; i++) begin : g_step
        logic [31:0]      rem_in;
        logic [31:0]      dvs_in;
        logic [DIV_W-1:0] dq_in;
        logic [32:0]      rem_sh;
        logic [32:0]      diff;
        logic             take;

        // The first stage starts from a zero remainder.
        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign dvs_in = mb;
            assign dq_in  = {ma, (FRAC_BITS + 1)'(0)};
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
            assign dq_in  = dq_reg[i-1];
        end

        // Shift in the next dividend bit and try the subtraction.
        always_comb begin
            rem_sh = {rem_in, dq_in[DIV_W-1]};
            diff   = rem_sh - {1'b0, dvs_in};
            take   = ~diff[32];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dq_reg[i] <= {dq_in[DIV_W-2:0], take};
            end
        end

        // The last stage needs no remainder.
        if (i < DIV_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= take ? diff[31:0] : rem_sh[31:0];
                    dvs_reg[i] <= dvs_in;
                end
            end
        end
    end

    assign quot = dq_reg[DIV_W-1];

endmodule

`default_nettype wire

### rtl/core/fpalu_skid.sv
// Output register with a skid stage that parts the pipeline from the result channel.
`default_nettype none

module fpalu_skid (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire fpalu_pkg::out_item_t in_data,
    output logic                      full,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output fpalu_pkg::out_item_t      m_item
);

    import fpalu_pkg::*;

    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;
    logic      push;
    logic      load_out;

    // An item arrives only while the skid stage is empty.
    assign push     = in_valid & ~skid_valid_reg;
    assign load_out = ~out_valid_reg | m_ready;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg  <= skid_valid_reg | push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (push) begin
            skid_data_reg <= in_data;
        end
    end

    assign full    = skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_item  = out_data_reg;

endmodule

`default_nettype wire

### rtl/core/fixed_point_q24_8_alu_top.sv
// Top level of the pipelined signed fixed-point ALU.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_item (operation, operand_a, operand_b)
//   m_      | out       | m_valid / m_ready  | m_item (result_value and five flags)
//
// One item enters per cycle while s_ready is high; each result passes the input register,
// the preparation register, the divider stages, the multiplier stage and the output
// register, and the divider resolves one quotient bit per stage.
// aresetn is synchronous and active low; it clears all valid bits and the output side.
// A stall on m_ready fills the skid stage, then freezes the whole pipeline; s_ready
// is low exactly while the skid stage holds an item.
`default_nettype none

module fixed_point_q24_8_alu_top #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire fpalu_pkg::in_item_t  s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output fpalu_pkg::out_item_t      m_item
);

    import fpalu_pkg::*;

    localparam int DIV_W = FRAC_BITS + 33;
    localparam int MUL_W = 65 - FRAC_BITS;

    logic en;
    logic skid_full;

    assign en      = ~skid_full;
    assign s_ready = en;

    // Input register.
    logic     in_valid_reg;
    in_item_t in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_item;
        end
    end

    // Operand preparation: magnitudes, compare flags and the operations that need neither multiplier nor divider.
    side_t prep_next;
    side_t prep_reg;
    logic  prep_valid_reg;
    logic  an;
    logic  bn;

    always_comb begin
        an = in_reg.operand_a[31];
        bn = in_reg.operand_b[31];
        prep_next.op  = in_reg.operation;
        prep_next.ma  = an ? 32'(-in_reg.operand_a) : in_reg.operand_a;
        prep_next.mb  = bn ? 32'(-in_reg.operand_b) : in_reg.operand_b;
        prep_next.neg = an ^ bn;
        prep_next.gt  = in_reg.operand_a > in_reg.operand_b;
        prep_next.lt  = in_reg.operand_a < in_reg.operand_b;
        prep_next.eq  = in_reg.operand_a == in_reg.operand_b;
        prep_next.dbz = (in_reg.operation == OP_DIV) && (in_reg.operand_b == 32'sd0);
        case (in_reg.operation)
            OP_ADD:      prep_next.simple = in_reg.operand_a + in_reg.operand_b;
            OP_SUB:      prep_next.simple = in_reg.operand_a - in_reg.operand_b;
            OP_MIN:      prep_next.simple = (in_reg.operand_a < in_reg.operand_b)
                                            ? in_reg.operand_a : in_reg.operand_b;
            OP_MAX:      prep_next.simple = (in_reg.operand_b < in_reg.operand_a)
                                            ? in_reg.operand_a : in_reg.operand_b;
            OP_INC:      prep_next.simple = in_reg.operand_a + 32'sd1;
            OP_DEC:      prep_next.simple = in_reg.operand_a - 32'sd1;
            OP_FROM_INT: prep_next.simple = in_reg.operand_a << FRAC_BITS;
            OP_TO_INT:   prep_next.simple = in_reg.operand_a >>> FRAC_BITS;
            default:     prep_next.simple = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            prep_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    // Divider, with the rest of the item carried beside it stage by stage.
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] side_valid_reg;
    side_t            side_reg [DIV_W];

    fpalu_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk (aclk),
        .en   (en),
        .ma   (prep_reg.ma),
        .mb   (prep_reg.mb),
        .quot (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_valid_reg <= '0;
        end else if (en) begin
            side_valid_reg <= {side_valid_reg[DIV_W-2:0], prep_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= prep_reg;
            for (int i = 1; i < DIV_W; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Multiplier stage; the quotient and side data are registered beside it.
    logic [63:0]      prod_reg;
    logic             mul_valid_reg;
    side_t            mul_side_reg;
    logic [DIV_W-1:0] mul_quot_reg;

    fpalu_mul u_mul (
        .aclk     (aclk),
        .en       (en),
        .ma       (side_reg[DIV_W-1].ma),
        .mb       (side_reg[DIV_W-1].mb),
        .prod_reg (prod_reg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= side_valid_reg[DIV_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_side_reg <= side_reg[DIV_W-1];
            mul_quot_reg <= quot;
        end
    end

    // Rounding half away from zero, saturation and result selection.
    logic [64:0]      mul_sum;
    logic [MUL_W-1:0] mul_mag;
    logic             mul_ovf;
    logic [31:0]      mul_res;
    logic [DIV_W:0]   div_sum;
    logic [DIV_W-1:0] div_mag;
    logic             div_ovf;
    logic [31:0]      div_res;
    out_item_t        final_item;

    always_comb begin
        mul_sum = {1'b0, prod_reg} + (65'd1 << (FRAC_BITS - 1));
        mul_mag = mul_sum[64:FRAC_BITS];
        mul_ovf = mul_side_reg.neg ? (mul_mag > MUL_W'(SAT_NEG))
                                   : (mul_mag > MUL_W'(SAT_POS));
        if (mul_ovf) begin
            mul_res = mul_side_reg.neg ? SAT_NEG : SAT_POS;
        end else begin
            mul_res = mul_side_reg.neg ? 32'(-mul_mag[31:0]) : mul_mag[31:0];
        end

        // The quotient holds twice the ratio, truncated, so add one and halve.
        div_sum = {1'b0, mul_quot_reg} + (DIV_W + 1)'(1);
        div_mag = div_sum[DIV_W:1];
        div_ovf = mul_side_reg.neg ? (div_mag > DIV_W'(SAT_NEG))
                                   : (div_mag > DIV_W'(SAT_POS));
        if (div_ovf) begin
            div_res = mul_side_reg.neg ? SAT_NEG : SAT_POS;
        end else begin
            div_res = mul_side_reg.neg ? 32'(-div_mag[31:0]) : div_mag[31:0];
        end

        final_item.a_greater      = mul_side_reg.gt;
        final_item.a_less         = mul_side_reg.lt;
        final_item.a_equal        = mul_side_reg.eq;
        final_item.divide_by_zero = mul_side_reg.dbz;
        case (mul_side_reg.op)
            OP_MUL: begin
                final_item.result_value = mul_res;
                final_item.overflow     = mul_ovf;
            end
            OP_DIV: begin
                final_item.result_value = mul_side_reg.dbz ? 32'sd0 : div_res;
                final_item.overflow     = ~mul_side_reg.dbz & div_ovf;
            end
            default: begin
                final_item.result_value = mul_side_reg.simple;
                final_item.overflow     = 1'b0;
            end
        endcase
    end

    // Output register and skid stage.
    fpalu_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (mul_valid_reg),
        .in_data  (final_item),
        .full     (skid_full),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    // A divide by zero gives a zero result and never reports overflow.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.divide_by_zero |-> m_item.result_value == 32'sd0 && !m_item.overflow)
        else $error("divide by zero result is not clean");

    // Exactly one of the three compare flags holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_item.a_greater, m_item.a_less, m_item.a_equal}))
        else $error("compare flags are not one-hot");

    // The input side only stalls while a result is waiting at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

endmodule

`default_nettype wire

### tb/tb_fixed_point_q24_8_alu_top.sv
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU top level.
`timescale 1ns / 1ps

module tb_fixed_point_q24_8_alu_top;

    import fpalu_pkg::*;

    localparam int FRAC_BITS      = 8;
    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int PRESSURE_AT    = 600;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT_NS     = 1_600_000;

    // Opcodes that the block leaves unused.
    localparam logic [3:0] OP_SPARE_FIRST = 4'd10;
    localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

    // One row of the directed table; known marks a result typed in by hand.
    typedef struct packed {
        in_item_t  item;
        logic      known;
        out_item_t want;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    out_item_t awaited_results[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        accepted_items = 0;
    int        burst_left = 0;

    fixed_point_q24_8_alu_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Exact ALU arithmetic: wrapping add/sub, rounded and saturated mul/div.
    function automatic out_item_t alu_result_of(input in_item_t it);
        out_item_t   res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mag;
        logic        neg;
        logic        saturating;
        logic        ovf;
        logic        dbz;
        a = it.operand_a;
        b = it.operand_b;
        ma = {32'd0, (a[31] ? (~a + 32'd1) : a)};
        mb = {32'd0, (b[31] ? (~b + 32'd1) : b)};
        neg = a[31] ^ b[31];
        saturating = 1'b0;
        ovf = 1'b0;
        dbz = 1'b0;
        mag = '0;
        r = '0;
        case (it.operation)
            OP_ADD:      r = a + b;
            OP_SUB:      r = a - b;
            OP_MUL: begin
                mag = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                saturating = 1'b1;
            end
            OP_DIV: begin
                if (b == 32'd0) begin
                    dbz = 1'b1;
                end else begin
                    mag = (((ma << FRAC_BITS) << 1) + mb) / (mb << 1);
                    saturating = 1'b1;
                end
            end
            OP_MIN:      r = ($signed(a) < $signed(b)) ? a : b;
            OP_MAX:      r = ($signed(b) < $signed(a)) ? a : b;
            OP_INC:      r = a + 32'd1;
            OP_DEC:      r = a - 32'd1;
            OP_FROM_INT: r = a << FRAC_BITS;
            OP_TO_INT:   r = $signed(a) >>> FRAC_BITS;
            default:     r = '0;
        endcase
        // Apply the sign to the magnitude and clamp into the 32-bit range.
        if (saturating) begin
            if (neg) begin
                if (mag > 64'h8000_0000) begin
                    ovf = 1'b1;
                    r = SAT_NEG;
                end else begin
                    r = ~mag[31:0] + 32'd1;
                end
            end else if (mag > 64'h7FFF_FFFF) begin
                ovf = 1'b1;
                r = SAT_POS;
            end else begin
                r = mag[31:0];
            end
        end
        res.result_value   = r;
        res.a_greater      = $signed(a) > $signed(b);
        res.a_less         = $signed(a) < $signed(b);
        res.a_equal        = (a == b);
        res.divide_by_zero = dbz;
        res.overflow       = ovf;
        return res;
    endfunction

    // Operands mix full-range words, small values, mid-range values and corners.
    function automatic logic [31:0] random_operand();
        int unsigned small_val;
        case ($urandom_range(0, 9))
            4, 5: begin
                small_val = $urandom_range(0, 4095) - 2048;
                return small_val;
            end
            6, 8: return $signed($urandom) >>> $urandom_range(4, 24);
            7: begin
                case ($urandom_range(0, 7))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'hFFFF_FFFF;
                    3:       return SAT_POS;
                    4:       return SAT_NEG;
                    5:       return 32'h0000_0100;
                    6:       return 32'hFFFF_FF00;
                    default: return 32'h0000_0080;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        if ($urandom_range(0, 99) < 95)
            it.operation = 4'($urandom_range(OP_ADD, OP_TO_INT));
        else
            it.operation = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        it.operand_a = random_operand();
        pick = $urandom_range(0, 99);
        if (pick < 8)
            it.operand_b = it.operand_a;
        else if (pick < 13)
            it.operand_b = '0;
        else
            it.operand_b = random_operand();
        return it;
    endfunction

    // Rows whose result comes from the predictor.
    task automatic add_row(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
        stim_row_t row;
        row.item = '{operation: op, operand_a: a, operand_b: b};
        row.known = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endtask

    // Rows whose result is typed in by hand; a nonzero flag argument means set.
    task automatic add_known_row(input logic [3:0] op, input logic [31:0] a,
                                 input logic [31:0] b, input logic [31:0] r,
                                 input int gt, input int lt, input int eq,
                                 input int dbz, input int ovf);
        stim_row_t row;
        row.item = '{operation: op, operand_a: a, operand_b: b};
        row.known = 1'b1;
        row.want = '{result_value: r, a_greater: (gt != 0), a_less: (lt != 0),
                     a_equal: (eq != 0), divide_by_zero: (dbz != 0),
                     overflow: (ovf != 0)};
        directed_rows.push_back(row);
    endtask

    // Sender pacing: bursts of back-to-back items separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    // Offer one item and hold it until accepted, then record its expected result.
    task automatic offer_item(input in_item_t it, input logic known, input out_item_t want);
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accepted_items++;
        awaited_results.push_back(known ? want : alu_result_of(it));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    // Compare each accepted result with the oldest expected one.
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result item %h", $realtime, m_item);
            end else begin
                want = awaited_results.pop_front();
                check_field("result_value", want.result_value, m_item.result_value);
                check_field("a_greater", 32'(want.a_greater), 32'(m_item.a_greater));
                check_field("a_less", 32'(want.a_less), 32'(m_item.a_less));
                check_field("a_equal", 32'(want.a_equal), 32'(m_item.a_equal));
                check_field("divide_by_zero", 32'(want.divide_by_zero),
                            32'(m_item.divide_by_zero));
                check_field("overflow", 32'(want.overflow), 32'(m_item.overflow));
            end
        end
    end

    // Result side: phases of varying stall rate, plus one long hold-off.
    initial begin : result_sink
        int   stall_pct;
        int   phase_left;
        logic pressure_done;
        stall_pct = 0;
        phase_left = 0;
        pressure_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!pressure_done && accepted_items >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (phase_left == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 20;
                    3:       stall_pct = 50;
                    default: stall_pct = 90;
                endcase
                phase_left = $urandom_range(10, 80);
            end
            phase_left--;
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
            @(posedge aclk);
        end
    end

    // Directed table, then random items, then drain and verdict.
    initial begin : stimulus
        stim_row_t row;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item <= '0;

        // Wrapping add and sub at the range limits.
        add_known_row(OP_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 1, 0, 0);
        add_known_row(OP_ADD, SAT_POS, 32'h0000_0001, SAT_NEG, 1, 0, 0, 0, 0);
        add_known_row(OP_SUB, SAT_NEG, 32'h0000_0001, SAT_POS, 0, 1, 0, 0, 0);
        // Multiply: positive saturation from both sign pairs, the exact negative limit, rounding of halves.
        add_known_row(OP_MUL, SAT_POS, SAT_POS, SAT_POS, 0, 0, 1, 0, 1);
        add_known_row(OP_MUL, SAT_NEG, SAT_NEG, SAT_POS, 0, 0, 1, 0, 1);
        add_known_row(OP_MUL, SAT_NEG, 32'h0000_0100, SAT_NEG, 0, 1, 0, 0, 0);
        add_row(OP_MUL, 32'h0000_0001, 32'h0000_0080);
        add_row(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
        add_row(OP_MUL, 32'h0000_0180, 32'h0000_0180);
        // Divide: by zero, saturation, ordinary rounded quotients.
        add_known_row(OP_DIV, 32'h0000_0100, 32'h0000_0000, 32'h0000_0000, 1, 0, 0, 1, 0);
        add_known_row(OP_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 1, 1, 0);
        add_known_row(OP_DIV, SAT_POS, 32'h0000_0001, SAT_POS, 1, 0, 0, 0, 1);
        add_known_row(OP_DIV, SAT_NEG, 32'h0000_0001, SAT_NEG, 0, 1, 0, 0, 1);
        add_known_row(OP_DIV, SAT_NEG, 32'hFFFF_FFFF, SAT_POS, 0, 1, 0, 0, 1);
        add_row(OP_DIV, 32'h0000_0100, 32'h0000_0300);
        add_row(OP_DIV, 32'hFFFF_FF00, 32'h0000_0200);
        // Min and max, including equal operands.
        add_row(OP_MIN, 32'h0000_0200, 32'h0000_0200);
        add_known_row(OP_MIN, SAT_NEG, SAT_POS, SAT_NEG, 0, 1, 0, 0, 0);
        add_known_row(OP_MAX, SAT_NEG, SAT_POS, SAT_POS, 0, 1, 0, 0, 0);
        // Increment and decrement wrap around.
        add_known_row(OP_INC, SAT_POS, 32'h0000_0000, SAT_NEG, 1, 0, 0, 0, 0);
        add_known_row(OP_DEC, SAT_NEG, 32'h0000_0000, SAT_POS, 0, 1, 0, 0, 0);
        // Conversions: wrapping shift up, flooring shift down.
        add_row(OP_FROM_INT, 32'h00FF_FFFF, 32'h0000_0000);
        add_row(OP_FROM_INT, 32'h8000_0001, 32'hFFFF_FFFF);
        add_row(OP_TO_INT, 32'hFFFF_FF01, 32'h0000_0000);
        add_known_row(OP_TO_INT, SAT_POS, SAT_POS, 32'h007F_FFFF, 0, 0, 1, 0, 0);
        // An unused opcode gives zero but still compares the operands.
        add_known_row(OP_SPARE_LAST, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000,
                      0, 1, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            pace_sender();
            offer_item(row.item, row.known, row.want);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pace_sender();
            offer_item(random_item(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            mismatch_count++;
            $display("%0d expected result items never arrived", awaited_results.size());
        end
        if (mismatch_count == 0) begin
            $display("fixed_point_q24_8_alu_top verification clean");
        end else begin
            $display("fixed_point_q24_8_alu_top verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("fixed_point_q24_8_alu_top verification failed");
        $finish;
    end

endmodule

### fixed_point_q24_8_alu_top.f
rtl/core/fpalu_pkg.sv
rtl/core/fpalu_mul.sv
rtl/core/fpalu_div.sv
rtl/core/fpalu_skid.sv
rtl/core/fixed_point_q24_8_alu_top.sv
tb/tb_fixed_point_q24_8_alu_top.sv
